### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the line stepper.
// No dependencies; included by files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Whenever ante holds at a clock edge, cons must hold at the same edge.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: ante implies cons");

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### hdl/bls_pkg.sv
// Package for the line stepper: widths, opcodes and the transaction types.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package bls_pkg;

  localparam int COORD_BITS  = 12;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int ERR_BITS    = COORD_BITS + 4;
  localparam int QUEUE_DEPTH = 4;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic        [DIFF_BITS-1:0]  mag_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;

  // One input transaction.
  typedef struct packed {
    logic   opcode;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } in_item_t;

  // One result transaction.
  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    logic   last_pixel;
  } out_item_t;

  // Decoded command as it sits in the queue between front and back.
  typedef struct packed {
    logic   is_load;
    logic   y_major;
    logic   minor_up;
    coord_t start_x;
    coord_t start_y;
    coord_t major_end;
    err_t   err_init;
    err_t   inc_hold;
    err_t   inc_step;
  } cmd_t;

  // Write side of the command queue.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

  // Fill status of the command queue.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hdl/bls_front.sv
// Front end of the line stepper: accepts transactions and decodes loads.
// Depends on bls_pkg; feeds bls_cmd_queue.
`timescale 1ns / 1ps

module bls_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  bls_pkg::in_item_t  in_data,
  input  bls_pkg::q_stat_t   q_stat,
  output bls_pkg::cmd_push_t q_push
);
  import bls_pkg::*;

  logic     stg_v_r;
  in_item_t stg_item_r;
  diff_t    dx_r;
  diff_t    dy_r;

  logic     advance;
  diff_t    dx_nxt;
  diff_t    dy_nxt;
  mag_t     abs_dx;
  mag_t     abs_dy;
  mag_t     abs_maj;
  mag_t     abs_min;
  logic     y_major;
  logic     major_fwd;
  err_t     maj_ext;
  err_t     min_dbl;
  err_t     maj_dbl;

  // The stage moves on whenever it is empty or the queue has room.
  assign advance = !stg_v_r || !q_stat.full;
  assign full    = !advance;

  // Endpoint differences, taken straight from the input ports.
  assign dx_nxt = $signed({in_data.end_x[COORD_BITS-1], in_data.end_x})
                - $signed({in_data.start_x[COORD_BITS-1], in_data.start_x});
  assign dy_nxt = $signed({in_data.end_y[COORD_BITS-1], in_data.end_y})
                - $signed({in_data.start_y[COORD_BITS-1], in_data.start_y});

  // Input register stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (advance) begin
      stg_v_r <= push;
    end
    if (advance) begin
      stg_item_r <= in_data;
      dx_r       <= dx_nxt;
      dy_r       <= dy_nxt;
    end
  end

  // Magnitudes, major axis and stepping direction.
  always_comb begin
    abs_dx    = dx_r[DIFF_BITS-1] ? mag_t'(-dx_r) : mag_t'(dx_r);
    abs_dy    = dy_r[DIFF_BITS-1] ? mag_t'(-dy_r) : mag_t'(dy_r);
    y_major   = abs_dy > abs_dx;
    abs_maj   = y_major ? abs_dy : abs_dx;
    abs_min   = y_major ? abs_dx : abs_dy;
    major_fwd = y_major ? !dy_r[DIFF_BITS-1] : !dx_r[DIFF_BITS-1];
    maj_ext   = err_t'({{(ERR_BITS-DIFF_BITS){1'b0}}, abs_maj});
    maj_dbl   = err_t'({{(ERR_BITS-DIFF_BITS-1){1'b0}}, abs_maj, 1'b0});
    min_dbl   = err_t'({{(ERR_BITS-DIFF_BITS-1){1'b0}}, abs_min, 1'b0});
  end

  // Build the queue entry; for steps only the opcode is used by the back end.
  always_comb begin
    q_push.valid        = stg_v_r && !q_stat.full;
    q_push.cmd.is_load  = (stg_item_r.opcode == OP_LOAD);
    q_push.cmd.y_major  = y_major;
    q_push.cmd.minor_up = (dx_r[DIFF_BITS-1] == dy_r[DIFF_BITS-1])
                          && (dx_r != '0) && (dy_r != '0);
    q_push.cmd.start_x  = major_fwd ? stg_item_r.start_x : stg_item_r.end_x;
    q_push.cmd.start_y  = major_fwd ? stg_item_r.start_y : stg_item_r.end_y;
    if (y_major) begin
      q_push.cmd.major_end = major_fwd ? stg_item_r.end_y : stg_item_r.start_y;
    end else begin
      q_push.cmd.major_end = major_fwd ? stg_item_r.end_x : stg_item_r.start_x;
    end
    q_push.cmd.err_init = min_dbl - maj_ext;
    q_push.cmd.inc_hold = min_dbl;
    q_push.cmd.inc_step = min_dbl - maj_dbl;
  end

endmodule

### hdl/bls_cmd_queue.sv
// Short command queue between the front end and the stepping back end.
// Depends on bls_pkg for the command type.
`timescale 1ns / 1ps

module bls_cmd_queue #(
  parameter int DEPTH = bls_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bls_pkg::cmd_push_t q_push,
  input  logic               q_pop,
  output bls_pkg::cmd_t      q_head,
  output bls_pkg::q_stat_t   q_stat
);
  import bls_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign q_stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = q_push.valid && !q_stat.full;
  assign do_pop       = q_pop && !q_stat.empty;
  assign q_head       = mem_r[rd_ptr_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_push.cmd;
    end
  end

endmodule

### hdl/bls_back.sv
// Back end of the line stepper: Bresenham state, stepping and result register.
// Depends on bls_pkg; reads commands from bls_cmd_queue.
`timescale 1ns / 1ps

module bls_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bls_pkg::cmd_t      q_head,
  input  bls_pkg::q_stat_t   q_stat,
  output logic               q_pop,
  output logic               empty,
  input  logic               pop,
  output bls_pkg::out_item_t out_data
);
  import bls_pkg::*;

  logic      active_r;
  logic      y_major_r;
  logic      minor_up_r;
  coord_t    cur_x_r;
  coord_t    cur_y_r;
  coord_t    major_end_r;
  err_t      err_r;
  err_t      inc_hold_r;
  err_t      inc_step_r;
  logic      out_v_r;
  out_item_t out_item_r;

  logic      take;
  logic      emit;
  logic      y_major_nxt;
  logic      minor_up_nxt;
  coord_t    cur_x_nxt;
  coord_t    cur_y_nxt;
  coord_t    major_end_nxt;
  err_t      err_nxt;
  err_t      inc_hold_nxt;
  err_t      inc_step_nxt;
  logic      last_nxt;
  logic      hold_minor;
  coord_t    minor_delta;

  // A command is consumed whenever the result register is free or drains.
  assign take  = !q_stat.empty && (!out_v_r || pop);
  assign q_pop = take;
  assign emit  = q_head.is_load || active_r;

  // Next line state for a load or one step.
  always_comb begin
    y_major_nxt   = y_major_r;
    minor_up_nxt  = minor_up_r;
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    major_end_nxt = major_end_r;
    err_nxt       = err_r;
    inc_hold_nxt  = inc_hold_r;
    inc_step_nxt  = inc_step_r;
    minor_delta   = minor_up_r ? coord_t'(1) : coord_t'(-1);
    hold_minor    = y_major_r ? (err_r <= 0) : (err_r < 0);
    if (q_head.is_load) begin
      y_major_nxt   = q_head.y_major;
      minor_up_nxt  = q_head.minor_up;
      cur_x_nxt     = q_head.start_x;
      cur_y_nxt     = q_head.start_y;
      major_end_nxt = q_head.major_end;
      err_nxt       = q_head.err_init;
      inc_hold_nxt  = q_head.inc_hold;
      inc_step_nxt  = q_head.inc_step;
    end else if (y_major_r) begin
      cur_y_nxt = cur_y_r + coord_t'(1);
      if (!hold_minor) begin
        cur_x_nxt = cur_x_r + minor_delta;
      end
      err_nxt = err_r + (hold_minor ? inc_hold_r : inc_step_r);
    end else begin
      cur_x_nxt = cur_x_r + coord_t'(1);
      if (!hold_minor) begin
        cur_y_nxt = cur_y_r + minor_delta;
      end
      err_nxt = err_r + (hold_minor ? inc_hold_r : inc_step_r);
    end
    last_nxt = y_major_nxt ? (cur_y_nxt >= major_end_nxt)
                           : (cur_x_nxt >= major_end_nxt);
  end

  // Line state; a step while idle leaves it untouched.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (take && emit) begin
      active_r <= !last_nxt;
    end
    if (take && emit) begin
      y_major_r   <= y_major_nxt;
      minor_up_r  <= minor_up_nxt;
      cur_x_r     <= cur_x_nxt;
      cur_y_r     <= cur_y_nxt;
      major_end_r <= major_end_nxt;
      err_r       <= err_nxt;
      inc_hold_r  <= inc_hold_nxt;
      inc_step_r  <= inc_step_nxt;
    end
  end

  // Result register on the output side.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (take && emit) begin
      out_v_r <= 1'b1;
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
    if (take && emit) begin
      out_item_r.pixel_x    <= cur_x_nxt;
      out_item_r.pixel_y    <= cur_y_nxt;
      out_item_r.last_pixel <= last_nxt;
    end
  end

  assign empty    = !out_v_r;
  assign out_data = out_item_r;

endmodule

### hdl/bresenham_line_stepper.sv
// Top level of the Bresenham line stepper: front end, command queue, back end.
// Depends on bls_pkg, bls_front, bls_cmd_queue, bls_back and assert_macros.svh.
//
//   channel   | handshake          | payload
//   ----------+--------------------+---------------------------------------
//   input     | push / full        | in_data  (opcode, start and end points)
//   result    | pop / empty        | out_data (pixel_x, pixel_y, last_pixel)
//
// One transaction per cycle is sustained while the result side pops; the pace is
// set by the back end's add and compare on the registered error term and coordinates.
// An accepted transaction passes through the input register, then the command queue,
// then the result register.
// Reset clears the queue, the line-active flag and both valid flags.
// A stalled result side fills the queue; full then rises and holds the input.
`timescale 1ns / 1ps

module bresenham_line_stepper #(
  parameter int QUEUE_DEPTH = bls_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  bls_pkg::in_item_t  in_data,
  output logic               empty,
  input  logic               pop,
  output bls_pkg::out_item_t out_data
);
  import bls_pkg::*;

  `include "assert_macros.svh"

  cmd_push_t q_push;
  cmd_t      q_head;
  q_stat_t   q_stat;
  logic      q_pop;

  // Accepts transactions and decodes line loads.
  bls_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .full    (full),
    .in_data (in_data),
    .q_stat  (q_stat),
    .q_push  (q_push)
  );

  // Decouples the front end from the back end.
  bls_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_pop  (q_pop),
    .q_head (q_head),
    .q_stat (q_stat)
  );

  // Steps the line and holds the waiting result.
  bls_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_head   (q_head),
    .q_stat   (q_stat),
    .q_pop    (q_pop),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  // The front end only writes when the queue has room.
  `ASSERT_IMPLY(a_push_room, clk, rst_n, q_push.valid, !q_stat.full)
  // The back end never reads an empty queue.
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, q_pop && q_stat.empty)
  // The input side is held only while the queue is full.
  `ASSERT_IMPLY(a_full_cause, clk, rst_n, full, q_stat.full)

endmodule

### test/tb_bresenham_line_stepper.sv
// Testbench for bresenham_line_stepper: directed rows, then random line traces.
// Depends on bls_pkg and the block under test; checks every pixel against a local tracer or typed row.
`timescale 1ns / 1ps

module tb_bresenham_line_stepper;
  import bls_pkg::*;

  localparam int PIXEL_TARGET = 1750;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_REPORTS  = 10;

  // How a directed row is checked.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_PIXEL} chk_t;

  typedef struct packed {
    in_item_t  item;
    chk_t      chk;
    out_item_t pix;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  logic      full;
  logic      empty;
  in_item_t  in_data = '0;
  out_item_t out_data;

  // Tracer state: a private copy of the line being drawn.
  coord_t cur_x, cur_y, line_end;
  int     adx, ady, err_acc;
  bit     line_y_major, line_up, line_active;

  out_item_t expected_pixels[$];
  int        fail_count = 0;
  int        pixels_planned = 0;
  bit        calm_stretch = 1'b0;

  // Directed rows: idle steps, degenerate lines, extremes, swaps, ties and abandon.
  dir_row_t dir_rows[25] = '{
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_NONE, '{0, 0, 0}},
    '{'{OP_LOAD, 0, 0, 0, 0}, CHK_PIXEL, '{0, 0, 1}},
    '{'{OP_STEP, -1, -1, -1, -1}, CHK_NONE, '{0, 0, 0}},
    '{'{OP_LOAD, -2048, 2047, -2048, 2047}, CHK_PIXEL, '{-2048, 2047, 1}},
    '{'{OP_LOAD, 2047, 5, 2044, 5}, CHK_PIXEL, '{2044, 5, 0}},
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_PIXEL, '{2047, 5, 1}},
    '{'{OP_LOAD, 3, -2048, 3, -2045}, CHK_PIXEL, '{3, -2048, 0}},
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_LOAD, 0, 0, 3, -3}, CHK_PIXEL, '{0, 0, 0}},
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_LOAD, 5, 5, 3, -1}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_LOAD, -10, -10, 10, 10}, CHK_PIXEL, '{-10, -10, 0}},
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_LOAD, -2048, -2048, 2047, 2047}, CHK_PIXEL, '{-2048, -2048, 0}},
    '{'{OP_STEP, 0, 0, 0, 0}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_LOAD, 2047, 2047, -2048, -2048}, CHK_MODEL, '{0, 0, 0}},
    '{'{OP_LOAD, 0, 0, 7, 2}, CHK_MODEL, '{0, 0, 0}}
  };

  bresenham_line_stepper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_data  (in_data),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Trace one transaction through the line state; returns 1 when a pixel comes out.
  function automatic bit trace_pixel(input in_item_t item, output out_item_t px);
    int  x1, y1, x2, y2, dx, dy;
    bit  last;
    px = '0;
    if (item.opcode == OP_LOAD) begin
      x1 = int'(item.start_x);
      y1 = int'(item.start_y);
      x2 = int'(item.end_x);
      y2 = int'(item.end_y);
      dx = x2 - x1;
      dy = y2 - y1;
      adx = (dx < 0) ? -dx : dx;
      ady = (dy < 0) ? -dy : dy;
      line_up = (dx < 0 && dy < 0) || (dx > 0 && dy > 0);
      line_y_major = ady > adx;
      // Order the endpoints so the major coordinate increases.
      if (!line_y_major) begin
        cur_x    = (dx >= 0) ? item.start_x : item.end_x;
        cur_y    = (dx >= 0) ? item.start_y : item.end_y;
        line_end = (dx >= 0) ? item.end_x : item.start_x;
        err_acc  = 2 * ady - adx;
      end else begin
        cur_x    = (dy >= 0) ? item.start_x : item.end_x;
        cur_y    = (dy >= 0) ? item.start_y : item.end_y;
        line_end = (dy >= 0) ? item.end_y : item.start_y;
        err_acc  = 2 * adx - ady;
      end
    end else begin
      if (!line_active) return 1'b0;
      // The x-major path steps the minor axis on a nonnegative error, y-major on a positive one.
      if (!line_y_major) begin
        cur_x = coord_t'(cur_x + 1);
        if (err_acc < 0) begin
          err_acc += 2 * ady;
        end else begin
          cur_y = line_up ? coord_t'(cur_y + 1) : coord_t'(cur_y - 1);
          err_acc += 2 * (ady - adx);
        end
      end else begin
        cur_y = coord_t'(cur_y + 1);
        if (err_acc <= 0) begin
          err_acc += 2 * adx;
        end else begin
          cur_x = line_up ? coord_t'(cur_x + 1) : coord_t'(cur_x - 1);
          err_acc += 2 * (adx - ady);
        end
      end
    end
    last = line_y_major ? (cur_y >= line_end) : (cur_x >= line_end);
    px.pixel_x    = cur_x;
    px.pixel_y    = cur_y;
    px.last_pixel = last;
    line_active   = !last;
    return 1'b1;
  endfunction

  // Present one transaction, with random idle cycles ahead of it, and record what it should give.
  task automatic send(input in_item_t item, input chk_t chk, input out_item_t typed,
                      output bit made);
    out_item_t px;
    while (!calm_stretch && $urandom_range(99) < 36) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (full) @(posedge clk);
    made = trace_pixel(item, px);
    if (chk == CHK_PIXEL) expected_pixels.push_back(typed);
    else if (chk == CHK_MODEL && made) expected_pixels.push_back(px);
  endtask

  // A load with random content, followed by steps that finish, overshoot or abandon the line.
  task automatic draw_random_line();
    in_item_t  item;
    out_item_t unused;
    int        dx, dy, span, steps, pick;
    bit        made;
    unused = '0;
    item.opcode  = OP_LOAD;
    item.start_x = coord_t'($urandom);
    item.start_y = coord_t'($urandom);
    pick = $urandom_range(99);
    if (pick < 10) begin
      item.end_x = coord_t'($urandom);
      item.end_y = coord_t'($urandom);
    end else begin
      dx = $urandom_range(24) - 12;
      dy = $urandom_range(24) - 12;
      if (pick < 20) dy = 0;
      else if (pick < 30) dx = 0;
      else if (pick < 38) dy = ($urandom_range(1) != 0) ? dx : -dx;
      item.end_x = coord_t'(item.start_x + dx);
      item.end_y = coord_t'(item.start_y + dy);
    end
    dx = int'(item.end_x) - int'(item.start_x);
    dy = int'(item.end_y) - int'(item.start_y);
    span = (dx < 0) ? -dx : dx;
    if (((dy < 0) ? -dy : dy) > span) span = (dy < 0) ? -dy : dy;
    pick = $urandom_range(99);
    if (span > 40) steps = $urandom_range(40);
    else if (pick < 75) steps = span + $urandom_range(2);
    else steps = $urandom_range(span);
    send(item, CHK_MODEL, unused, made);
    pixels_planned += made;
    repeat (steps) begin
      item = in_item_t'({$urandom, $urandom});
      // Mostly steps; now and then a stray transaction with random opcode.
      item.opcode = ($urandom_range(99) < 95) ? OP_STEP : logic'($urandom_range(1));
      send(item, CHK_MODEL, unused, made);
      pixels_planned += made;
    end
  endtask

  task automatic report_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS)
      $display("%0t: %s: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
               $realtime, what, want.pixel_x, want.pixel_y, want.last_pixel,
               got.pixel_x, got.pixel_y, got.last_pixel);
  endtask

  // Result side: check each popped pixel against the oldest expectation, pop at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_pixels.size() == 0) begin
          report_mismatch("pixel with none expected", '0, out_data);
        end else begin
          if (out_data.pixel_x !== expected_pixels[0].pixel_x ||
              out_data.pixel_y !== expected_pixels[0].pixel_y ||
              out_data.last_pixel !== expected_pixels[0].last_pixel)
            report_mismatch("pixel mismatch", expected_pixels[0], out_data);
          void'(expected_pixels.pop_front());
        end
      end
      pop <= calm_stretch || ($urandom_range(99) >= 36);
    end
  end

  // Watchdog: end the run when no transaction moves on either side for too long.
  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (push && !full) || (pop && !empty)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Main sequence: reset, directed rows, random lines, drain.
  initial begin
    bit made;
    int next_drain;
    cur_x = '0;
    cur_y = '0;
    line_end = '0;
    adx = 0;
    ady = 0;
    err_acc = 0;
    line_y_major = 1'b0;
    line_up = 1'b0;
    line_active = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].chk, dir_rows[i].pix, made);

    next_drain = 300;
    while (pixels_planned < PIXEL_TARGET) begin
      calm_stretch = (pixels_planned >= 600 && pixels_planned < 900);
      // Hold the input until every outstanding pixel has come back.
      if (pixels_planned >= next_drain) begin
        next_drain += 500;
        push <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0) @(posedge clk);
      end
      draw_random_line();
    end
    calm_stretch = 1'b0;
    push <= 1'b0;

    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
